// ===== src/blr_pkg.sv =====
// Package for the line rasterizer: shared constants, codes and the line flag struct.
// No dependencies; imported by every module of the block.
package blr_pkg;

   localparam int COORD_BITS_DEF   = 12;
   localparam int OFFSET_BITS      = 28;
   localparam int COLOR_BITS       = 32;
   localparam int STRIDE_BITS      = 16;
   localparam int BPP_BITS         = 4;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 32;

   // reset values of the control registers
   localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 16'd2400;
   localparam logic [BPP_BITS-1:0]    BPP_RESET    = 4'd4;
   localparam logic [COLOR_BITS-1:0]  COLOR_RESET  = 32'h00f4c0ff;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_STRIDE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BPP        = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLOR      = 2'd2;

   // request action codes
   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_STEP = 1'b1;

   typedef struct packed {
      logic active;      // a line is being drawn
      logic steep;       // y is the major axis
      logic minor_neg;   // minor coordinate counts down
   } line_flags_type;

endpackage

// ===== src/blr_line_setup.sv =====
// Line setup: endpoint ordering, octant choice, error term and increments.
// Depends on blr_pkg.
module blr_line_setup #(
   parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
   input  logic [COORD_BITS-1:0]        start_x,
   input  logic [COORD_BITS-1:0]        start_y,
   input  logic [COORD_BITS-1:0]        end_x,
   input  logic [COORD_BITS-1:0]        end_y,
   output blr_pkg::line_flags_type      flags,
   output logic [COORD_BITS-1:0]        first_x,
   output logic [COORD_BITS-1:0]        first_y,
   output logic [COORD_BITS-1:0]        major_end,
   output logic signed [COORD_BITS+3:0] error_init,
   output logic signed [COORD_BITS+1:0] inc_pos,
   output logic signed [COORD_BITS+1:0] inc_neg
);
   import blr_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int EW = COORD_BITS + 4;
   localparam int IW = COORD_BITS + 2;

   logic signed [DW-1:0]   dx, dy, adx, ady, major, minor, minor_abs;
   logic                   steep, swap;
   logic [COORD_BITS-1:0]  x0, y0, x1, y1;

   always_comb begin
      dx    = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
      dy    = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
      adx   = dx[DW-1] ? -dx : dx;
      ady   = dy[DW-1] ? -dy : dy;
      steep = !(ady < adx);
      swap  = steep ? (start_y > end_y) : (start_x > end_x);
      x0    = swap ? end_x   : start_x;
      y0    = swap ? end_y   : start_y;
      x1    = swap ? start_x : end_x;
      y1    = swap ? start_y : end_y;
      if (steep) begin
         major = $signed({1'b0, y1}) - $signed({1'b0, y0});
         minor = $signed({1'b0, x1}) - $signed({1'b0, x0});
      end else begin
         major = $signed({1'b0, x1}) - $signed({1'b0, x0});
         minor = $signed({1'b0, y1}) - $signed({1'b0, y0});
      end
      minor_abs = minor[DW-1] ? -minor : minor;

      flags.active    = (major != '0);
      flags.steep     = steep;
      flags.minor_neg = minor[DW-1];
      first_x    = x0;
      first_y    = y0;
      major_end  = steep ? y1 : x1;
      error_init = (EW'(minor_abs) <<< 1) - EW'(major);
      inc_pos    = (IW'(minor_abs) - IW'(major)) <<< 1;
      inc_neg    = IW'(minor_abs) <<< 1;
   end

endmodule

// ===== src/blr_step.sv =====
// Pixel step: emits the current pixel and its byte offset, advances the error term.
// Depends on blr_pkg.
module blr_step #(
   parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
   input  blr_pkg::line_flags_type                flags,
   input  logic [COORD_BITS-1:0]                  cur_x,
   input  logic [COORD_BITS-1:0]                  cur_y,
   input  logic [COORD_BITS-1:0]                  major_end,
   input  logic signed [COORD_BITS+3:0]           error_term,
   input  logic signed [COORD_BITS+1:0]           inc_pos,
   input  logic signed [COORD_BITS+1:0]           inc_neg,
   input  logic [blr_pkg::STRIDE_BITS-1:0]        row_stride,
   input  logic [blr_pkg::BPP_BITS-1:0]           bpp,
   output logic [COORD_BITS-1:0]                  next_x,
   output logic [COORD_BITS-1:0]                  next_y,
   output logic signed [COORD_BITS+3:0]           next_error,
   output logic                                   last,
   output logic [blr_pkg::OFFSET_BITS-1:0]        byte_offset
);
   import blr_pkg::*;

   localparam int EW = COORD_BITS + 4;
   localparam int PW = (COORD_BITS + STRIDE_BITS > OFFSET_BITS) ?
                       COORD_BITS + STRIDE_BITS : OFFSET_BITS;

   logic                   err_pos;
   logic [COORD_BITS-1:0]  minor_src, minor_mv, minor_nxt, major_nxt;
   logic [PW-1:0]          row_part, col_part;

   always_comb begin
      err_pos   = !error_term[EW-1] && (error_term != '0);
      minor_src = flags.steep ? cur_x : cur_y;
      minor_mv  = flags.minor_neg ? minor_src - COORD_BITS'(1) : minor_src + COORD_BITS'(1);
      minor_nxt = err_pos ? minor_mv : minor_src;
      major_nxt = (flags.steep ? cur_y : cur_x) + COORD_BITS'(1);
      next_x    = flags.steep ? minor_nxt : major_nxt;
      next_y    = flags.steep ? major_nxt : minor_nxt;
      next_error = error_term + (err_pos ? EW'(inc_pos) : EW'(inc_neg));
      last      = (major_nxt == major_end);

      // offset wraps at 2^28
      row_part    = PW'(cur_y) * PW'(row_stride);
      col_part    = PW'(cur_x) * PW'(bpp);
      byte_offset = OFFSET_BITS'(row_part + col_part);
   end

endmodule

// ===== src/blr_out_skid.sv =====
// Two-entry result buffer: output register plus skid register.
// Depends on blr_pkg.
module blr_out_skid #(
   parameter int DATA_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [DATA_BITS-1:0] in_data,
   output logic                 full,
   output logic                 out_valid,
   input  logic                 out_stall,
   output logic [DATA_BITS-1:0] out_data
);
   import blr_pkg::*;

   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   logic [DATA_BITS-1:0] out_data_ff, out_data_in;
   logic [DATA_BITS-1:0] skid_data_ff, skid_data_in;
   logic                 out_free;

   always_comb begin
      out_free      = !out_valid_ff || !out_stall;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ===== src/bresenham_line_rasterizer_unit.sv =====
// Top level of the Bresenham line rasterizer: line state, control registers, result buffer.
// Depends on blr_pkg, blr_line_setup, blr_step and blr_out_skid.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------------
//  req     | in  | req_valid / req_stall  | action, start_x, start_y, end_x, end_y
//  rsp     | out | rsp_valid / rsp_stall  | pixel_x, pixel_y, byte_offset, color, last
//  csr     | in  | csr_valid / csr_ready  | csr_index, csr_wdata (write only)
//
// One request word per clock while req_stall is low. A load word sets up the line in the
// cycle it is taken and gives no response; a step word's pixel is registered into the
// result buffer. The rate is set by the combinational error term / coordinate update.
// Reset (synchronous, active high) drops any line and restores the register defaults.
// Stalls: results sit in a two-entry buffer; req_stall rises only once both entries hold
// a word, so a step is still taken while one finished pixel waits on rsp_stall.
module bresenham_line_rasterizer_unit #(
   parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [COORD_BITS-1:0]               req_start_x,
   input  logic [COORD_BITS-1:0]               req_start_y,
   input  logic [COORD_BITS-1:0]               req_end_x,
   input  logic [COORD_BITS-1:0]               req_end_y,
   // response
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [COORD_BITS-1:0]               rsp_pixel_x,
   output logic [COORD_BITS-1:0]               rsp_pixel_y,
   output logic [blr_pkg::OFFSET_BITS-1:0]     rsp_byte_offset,
   output logic [blr_pkg::COLOR_BITS-1:0]      rsp_color,
   output logic                                rsp_last,
   // control register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [blr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [blr_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import blr_pkg::*;

   localparam int EW = COORD_BITS + 4;   // error term
   localparam int IW = COORD_BITS + 2;   // increments
   localparam int RW = 2 * COORD_BITS + OFFSET_BITS + COLOR_BITS + 1;

   // control registers
   logic [STRIDE_BITS-1:0] row_stride_ff, row_stride_in;
   logic [BPP_BITS-1:0]    bpp_ff, bpp_in;
   logic [COLOR_BITS-1:0]  color_ff, color_in;

   // line state
   line_flags_type         flags_ff, flags_in;
   logic [COORD_BITS-1:0]  cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0]  cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0]  major_end_ff, major_end_in;
   logic signed [EW-1:0]   error_ff, error_in;
   logic signed [IW-1:0]   inc_pos_ff, inc_pos_in;
   logic signed [IW-1:0]   inc_neg_ff, inc_neg_in;

   // setup outputs
   line_flags_type         ld_flags;
   logic [COORD_BITS-1:0]  ld_x, ld_y, ld_major_end;
   logic signed [EW-1:0]   ld_error;
   logic signed [IW-1:0]   ld_inc_pos, ld_inc_neg;

   // step outputs
   logic [COORD_BITS-1:0]  st_x, st_y;
   logic signed [EW-1:0]   st_error;
   logic                   st_last;
   logic [OFFSET_BITS-1:0] st_offset;

   logic                   req_take, do_load, do_step, rsp_push;
   logic [RW-1:0]          rsp_word, rsp_data;

   blr_line_setup #(.COORD_BITS(COORD_BITS)) u_setup (
      .start_x    (req_start_x),
      .start_y    (req_start_y),
      .end_x      (req_end_x),
      .end_y      (req_end_y),
      .flags      (ld_flags),
      .first_x    (ld_x),
      .first_y    (ld_y),
      .major_end  (ld_major_end),
      .error_init (ld_error),
      .inc_pos    (ld_inc_pos),
      .inc_neg    (ld_inc_neg)
   );

   blr_step #(.COORD_BITS(COORD_BITS)) u_step (
      .flags       (flags_ff),
      .cur_x       (cur_x_ff),
      .cur_y       (cur_y_ff),
      .major_end   (major_end_ff),
      .error_term  (error_ff),
      .inc_pos     (inc_pos_ff),
      .inc_neg     (inc_neg_ff),
      .row_stride  (row_stride_ff),
      .bpp         (bpp_ff),
      .next_x      (st_x),
      .next_y      (st_y),
      .next_error  (st_error),
      .last        (st_last),
      .byte_offset (st_offset)
   );

   // request decode; a step on an idle line is taken and dropped
   always_comb begin
      req_take = req_valid && !req_stall;
      do_load  = req_take && (req_action == ACTION_LOAD);
      do_step  = req_take && (req_action == ACTION_STEP) && flags_ff.active;
      rsp_push = do_step;
      rsp_word = {cur_x_ff, cur_y_ff, st_offset, color_ff, st_last};
   end

   // next line state
   always_comb begin
      flags_in     = flags_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      major_end_in = major_end_ff;
      error_in     = error_ff;
      inc_pos_in   = inc_pos_ff;
      inc_neg_in   = inc_neg_ff;
      if (do_load) begin
         flags_in     = ld_flags;
         cur_x_in     = ld_x;
         cur_y_in     = ld_y;
         major_end_in = ld_major_end;
         error_in     = ld_error;
         inc_pos_in   = ld_inc_pos;
         inc_neg_in   = ld_inc_neg;
      end else if (do_step) begin
         cur_x_in        = st_x;
         cur_y_in        = st_y;
         error_in        = st_error;
         flags_in.active = !st_last;
      end
   end

   // register writes; unknown index ignored
   always_comb begin
      row_stride_in = row_stride_ff;
      bpp_in        = bpp_ff;
      color_in      = color_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROW_STRIDE: row_stride_in = csr_wdata[STRIDE_BITS-1:0];
            CSR_BPP:        bpp_in        = csr_wdata[BPP_BITS-1:0];
            CSR_COLOR:      color_in      = csr_wdata[COLOR_BITS-1:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff      <= '0;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         major_end_ff  <= '0;
         error_ff      <= '0;
         inc_pos_ff    <= '0;
         inc_neg_ff    <= '0;
         row_stride_ff <= STRIDE_RESET;
         bpp_ff        <= BPP_RESET;
         color_ff      <= COLOR_RESET;
      end else begin
         flags_ff      <= flags_in;
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         major_end_ff  <= major_end_in;
         error_ff      <= error_in;
         inc_pos_ff    <= inc_pos_in;
         inc_neg_ff    <= inc_neg_in;
         row_stride_ff <= row_stride_in;
         bpp_ff        <= bpp_in;
         color_ff      <= color_in;
      end
   end

   blr_out_skid #(.DATA_BITS(RW)) u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rsp_push),
      .in_data   (rsp_word),
      .full      (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign csr_ready = 1'b1;
   assign {rsp_pixel_x, rsp_pixel_y, rsp_byte_offset, rsp_color, rsp_last} = rsp_data;

   // skid entry never holds a word ahead of the output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("skid holds a word while rsp is empty");

   // pixel pushed into a held output must fill the skid and block requests
   a_push_on_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && rsp_push) |=> req_stall)
      else $error("pixel pushed on held output but request side not stalled");

   // final pixel ends the line
   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (do_step && st_last) |=> !flags_ff.active)
      else $error("line still active after its last pixel");

   // zero-length line never becomes active
   a_zero_length: assert property (@(posedge clock) disable iff (reset)
      (do_load && (req_start_x == req_end_x) && (req_start_y == req_end_y))
      |=> !flags_ff.active)
      else $error("zero-length line left active");

endmodule

// ===== test/bresenham_line_rasterizer_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for bresenham_line_rasterizer_unit: a directed table, then random line
// runs under random gaps and stalls, pixel words checked by an in-bench tracer or typed rows.
// Depends on blr_pkg and the RTL of the block.
module bresenham_line_rasterizer_unit_tb;
   import blr_pkg::*;

   localparam int CB           = COORD_BITS_DEF;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1350;
   localparam int PHASES       = 8;
   localparam int MAX_REPORTS  = 10;
   // index 3 has no register behind it; writes there must be dropped
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [CB-1:0]          x;
      logic [CB-1:0]          y;
      logic [OFFSET_BITS-1:0] offset;
      logic [COLOR_BITS-1:0]  color;
      logic                   last;
   } pixel_word_type;

   // how a table row is checked: by the tracer, as giving nothing, or against a typed word
   typedef enum logic [1:0] {CHK_TRACER, CHK_NONE, CHK_TYPED} row_check_type;

   typedef struct packed {
      logic           act;
      logic [CB-1:0]  sx;
      logic [CB-1:0]  sy;
      logic [CB-1:0]  ex;
      logic [CB-1:0]  ey;
      row_check_type  chk;
      pixel_word_type word;
   } table_row_type;

   // DUT ports; every input is known from time zero
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_action = ACTION_STEP;
   logic [CB-1:0]             req_start_x = '0;
   logic [CB-1:0]             req_start_y = '0;
   logic [CB-1:0]             req_end_x = '0;
   logic [CB-1:0]             req_end_y = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [CB-1:0]             rsp_pixel_x;
   logic [CB-1:0]             rsp_pixel_y;
   logic [OFFSET_BITS-1:0]    rsp_byte_offset;
   logic [COLOR_BITS-1:0]     rsp_color;
   logic                      rsp_last;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_ROW_STRIDE;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // tracer copy of the registers and line state, as they stand after reset
   logic [STRIDE_BITS-1:0] stride_q = STRIDE_RESET;
   logic [BPP_BITS-1:0]    bpp_q    = BPP_RESET;
   logic [COLOR_BITS-1:0]  color_q  = COLOR_RESET;
   line_flags_type         flags    = '0;
   logic [CB-1:0]          at_x = '0;
   logic [CB-1:0]          at_y = '0;
   logic [CB-1:0]          major_end = '0;
   logic signed [15:0]     err = '0;
   logic signed [13:0]     inc_pos = '0;
   logic signed [13:0]     inc_nonpos = '0;

   pixel_word_type pixels_due[$];   // pixels predicted but not yet seen on rsp
   table_row_type  directed_rows[$];
   int          fail_count = 0;
   int          cycle_count = 0;
   int          items_done = 0;   // loads plus steps that drew a pixel
   int          stall_left = 0;
   bit          quiet = 1'b0;     // no gaps and no stalls while set

   bresenham_line_rasterizer_unit #(
      .COORD_BITS(CB)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_start_x(req_start_x),
      .req_start_y(req_start_y),
      .req_end_x(req_end_x),
      .req_end_y(req_end_y),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pixel_x(rsp_pixel_x),
      .rsp_pixel_y(rsp_pixel_y),
      .rsp_byte_offset(rsp_byte_offset),
      .rsp_color(rsp_color),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Line set-up: endpoints swapped so the major axis counts up; ties in |dx|, |dy| go steep.
   task automatic trace_load(input logic [CB-1:0] x0_in, y0_in, x1_in, y1_in);
      int x0, y0, x1, y1, adx, ady, major, minor, t;
      x0 = x0_in;
      y0 = y0_in;
      x1 = x1_in;
      y1 = y1_in;
      adx = (x1 > x0) ? x1 - x0 : x0 - x1;
      ady = (y1 > y0) ? y1 - y0 : y0 - y1;
      flags.steep = !(ady < adx);
      if ((!flags.steep && x0 > x1) || (flags.steep && y0 > y1)) begin
         t = x0; x0 = x1; x1 = t;
         t = y0; y0 = y1; y1 = t;
      end
      if (flags.steep) begin
         major = y1 - y0;
         minor = x1 - x0;
         major_end = CB'(y1);
      end else begin
         major = x1 - x0;
         minor = y1 - y0;
         major_end = CB'(x1);
      end
      flags.minor_neg = minor < 0;
      if (minor < 0) minor = -minor;
      at_x = CB'(x0);
      at_y = CB'(y0);
      err = 16'(2 * minor - major);
      inc_pos = 14'(2 * (minor - major));
      inc_nonpos = 14'(2 * minor);
      flags.active = major > 0;   // zero-length line never goes active
   endtask

   // One step: returns 1 with the pixel drawn, or 0 when no line is active (state untouched).
   function automatic bit trace_pixel(output pixel_word_type px);
      logic [63:0] full;
      full = 64'(at_y) * 64'(stride_q) + 64'(at_x) * 64'(bpp_q);
      px = '0;
      if (!flags.active) return 1'b0;
      px.x = at_x;
      px.y = at_y;
      px.offset = full[OFFSET_BITS-1:0];   // wraps modulo 2^28
      px.color = color_q;
      if (err > 0) begin
         if (flags.steep) at_x = flags.minor_neg ? at_x - 1'b1 : at_x + 1'b1;
         else at_y = flags.minor_neg ? at_y - 1'b1 : at_y + 1'b1;
         err = err + inc_pos;
      end else begin
         err = err + inc_nonpos;
      end
      if (flags.steep) begin
         at_y = at_y + 1'b1;
         px.last = at_y == major_end;
      end else begin
         at_x = at_x + 1'b1;
         px.last = at_x == major_end;
      end
      if (px.last) flags.active = 1'b0;   // far endpoint itself is never drawn
      return 1'b1;
   endfunction

   function automatic table_row_type row(logic act, int sx, int sy, int ex, int ey,
                                         row_check_type chk, pixel_word_type word);
      row = '{act: act, sx: CB'(sx), sy: CB'(sy), ex: CB'(ex), ey: CB'(ey),
              chk: chk, word: word};
   endfunction

   // random coordinate within span of c, clamped to the grid
   function automatic logic [CB-1:0] near(logic [CB-1:0] c, int span);
      int v;
      v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
      if (v < 0) v = 0;
      if (v > (1 << CB) - 1) v = (1 << CB) - 1;
      return CB'(v);
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
   endtask

   // Request word: optional gap, then hold valid and payload until taken; predict on accept.
   // Valid is left high so a zero gap gives back-to-back words.
   task automatic send_word(input logic act, input logic [CB-1:0] sx, sy, ex, ey,
                            input row_check_type chk, input pixel_word_type typed);
      int gap;
      pixel_word_type px;
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x <= ex;
      req_end_y <= ey;
      do @(posedge clock); while (req_stall);
      if (act == ACTION_LOAD) begin
         trace_load(sx, sy, ex, ey);
         items_done++;
      end else if (trace_pixel(px)) begin
         items_done++;
         if (chk == CHK_TRACER) pixels_due.push_back(px);
      end
      if (chk == CHK_TYPED) pixels_due.push_back(typed);
   endtask

   // coordinates ride along on a step but are ignored, so fill them with noise
   task automatic step_word();
      send_word(ACTION_STEP, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom),
                CHK_TRACER, '0);
   endtask

   task automatic load_word(input logic [CB-1:0] sx, sy, ex, ey);
      send_word(ACTION_LOAD, sx, sy, ex, ey, CHK_TRACER, '0);
   endtask

   // drop valid, drain every expected pixel, then let the pipe go quiet
   task automatic settle(input int hold);
      req_valid <= 1'b0;
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (hold) @(posedge clock);
   endtask

   // csr valid stays high across a burst; the caller lowers it after the last write
   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ROW_STRIDE: stride_q = data[STRIDE_BITS-1:0];
         CSR_BPP:        bpp_q = data[BPP_BITS-1:0];
         CSR_COLOR:      color_q = data;
         default:        ;
      endcase
   endtask

   // upper bits carry noise to show they are masked; spare index goes last so a stray
   // write there would corrupt a register and show up in the pixels
   task automatic program_regs(input logic [STRIDE_BITS-1:0] stride,
                               input logic [BPP_BITS-1:0] bpp,
                               input logic [COLOR_BITS-1:0] col);
      csr_write(CSR_ROW_STRIDE, {16'($urandom), stride});
      csr_write(CSR_BPP, {28'($urandom), bpp});
      csr_write(CSR_COLOR, col);
      csr_write(CSR_SPARE, $urandom);
      csr_valid <= 1'b0;
   endtask

   // One random run: mostly whole short lines, some longer ones, some dropped mid-line by
   // the next load, some zero-length lines and some stray steps.
   task automatic random_run();
      int pick, n;
      logic [CB-1:0] sx, sy, ex, ey;
      pick = $urandom_range(0, 99);
      sx = CB'($urandom);
      sy = CB'($urandom);
      if ($urandom_range(0, 7) == 0) sx = $urandom_range(0, 1) ? '1 : '0;
      if ($urandom_range(0, 7) == 0) sy = $urandom_range(0, 1) ? '1 : '0;
      ex = near(sx, 12);
      ey = near(sy, 12);
      n = $urandom_range(0, 2);
      if (pick < 72) begin
         if (pick >= 62) begin
            ex = near(sx, 120);
            ey = near(sy, 120);
         end
         load_word(sx, sy, ex, ey);
         while (flags.active) step_word();
      end else if (pick < 84) begin
         // full-range endpoints: long line, only its head is drawn
         load_word(sx, sy, CB'($urandom), CB'($urandom));
         n = $urandom_range(0, 6);
      end else if (pick < 92) begin
         load_word(sx, sy, sx, sy);
      end else begin
         n = $urandom_range(1, 3);
      end
      repeat (n) step_word();
   endtask

   // Result side: check each taken word against the oldest prediction, then draw a stall.
   always @(posedge clock) begin : rsp_monitor
      pixel_word_type got;
      pixel_word_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_pixel_x, rsp_pixel_y, rsp_byte_offset, rsp_color, rsp_last};
            if (pixels_due.size() == 0) begin
               note_failure($sformatf("unexpected pixel x=%0d y=%0d off=%0d col=%h last=%b",
                                      got.x, got.y, got.offset, got.color, got.last));
            end else begin
               want = pixels_due.pop_front();
               if (got.x !== want.x || got.y !== want.y || got.offset !== want.offset ||
                   got.color !== want.color || got.last !== want.last)
                  note_failure({
                     $sformatf("pixel mismatch exp x=%0d y=%0d off=%0d col=%h last=%b",
                               want.x, want.y, want.offset, want.color, want.last),
                     $sformatf(", got x=%0d y=%0d off=%0d col=%h last=%b",
                               got.x, got.y, got.offset, got.color, got.last)});
            end
            stall_left = quiet ? 0 : $urandom_range(0, 19);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= stall_left != 0;
      end
   end

   // Watchdog: a hung handshake or a lost pixel ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bresenham_line_rasterizer_unit test failed");
         $finish;
      end
   end

   initial begin : stimulus
      int target;
      // Directed table, register defaults. Typed words are read straight off the geometry:
      // (0,0)->(2,0) gives (0,0) then (1,0) as last; (4095,4095)->(4094,4095) swaps and
      // gives the single pixel (4094,4095) at 4095*2400 + 4094*4.
      directed_rows.push_back(row(ACTION_STEP, 0, 0, 0, 0, CHK_NONE, '0));   // no line yet
      directed_rows.push_back(row(ACTION_LOAD, 0, 0, 0, 0, CHK_NONE, '0));   // zero length
      directed_rows.push_back(row(ACTION_STEP, 0, 0, 0, 0, CHK_NONE, '0));
      directed_rows.push_back(row(ACTION_LOAD, 0, 0, 2, 0, CHK_NONE, '0));
      directed_rows.push_back(row(ACTION_STEP, 0, 0, 0, 0, CHK_TYPED,
                                  {12'd0, 12'd0, 28'd0, COLOR_RESET, 1'b0}));
      directed_rows.push_back(row(ACTION_STEP, 4095, 4095, 4095, 4095, CHK_TYPED,
                                  {12'd1, 12'd0, 28'd4, COLOR_RESET, 1'b1}));
      directed_rows.push_back(row(ACTION_STEP, 0, 0, 0, 0, CHK_NONE, '0));   // line done
      directed_rows.push_back(row(ACTION_LOAD, 4095, 4095, 4094, 4095, CHK_NONE, '0));
      directed_rows.push_back(row(ACTION_STEP, 0, 0, 0, 0, CHK_TYPED,
                                  {12'd4094, 12'd4095, 28'd9844376, COLOR_RESET, 1'b1}));
      // full anti-diagonal: steep on the tie, swapped, minor counting down
      directed_rows.push_back(row(ACTION_LOAD, 0, 4095, 4095, 0, CHK_TRACER, '0));
      repeat (3) directed_rows.push_back(row(ACTION_STEP, 0, 0, 0, 0, CHK_TRACER, '0));
      // load mid-line drops the diagonal; short steep line, swapped, x falling
      directed_rows.push_back(row(ACTION_LOAD, 5, 10, 6, 7, CHK_TRACER, '0));
      repeat (3) directed_rows.push_back(row(ACTION_STEP, 0, 0, 0, 0, CHK_TRACER, '0));
      directed_rows.push_back(row(ACTION_STEP, 0, 0, 0, 0, CHK_NONE, '0));
      // shallow with y falling
      directed_rows.push_back(row(ACTION_LOAD, 100, 1000, 3000, 200, CHK_TRACER, '0));
      repeat (2) directed_rows.push_back(row(ACTION_STEP, 0, 0, 0, 0, CHK_TRACER, '0));
      // steep, no swap, x falling
      directed_rows.push_back(row(ACTION_LOAD, 3000, 100, 10, 4000, CHK_TRACER, '0));
      directed_rows.push_back(row(ACTION_STEP, 0, 0, 0, 0, CHK_TRACER, '0));
      // main diagonal, corner to corner
      directed_rows.push_back(row(ACTION_LOAD, 0, 0, 4095, 4095, CHK_TRACER, '0));
      directed_rows.push_back(row(ACTION_STEP, 0, 0, 0, 0, CHK_TRACER, '0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].act, directed_rows[i].sx, directed_rows[i].sy,
                   directed_rows[i].ex, directed_rows[i].ey, directed_rows[i].chk,
                   directed_rows[i].word);

      // Random phases, registers rewritten while idle: zero, all-ones (offset wraps),
      // then mixed. bpp above eight is used as written. Every third phase runs flat out.
      for (int ph = 0; ph < PHASES; ph++) begin
         settle(4);
         case (ph)
            0: program_regs(16'd0, 4'd0, 32'd0);
            1: program_regs('1, '1, '1);
            2: program_regs(16'd1, 4'd8, $urandom);
            default: program_regs(16'($urandom),
                                  ($urandom_range(0, 3) == 0) ? 4'($urandom)
                                                              : 4'($urandom_range(1, 8)),
                                  $urandom);
         endcase
         quiet = (ph % 3) == 1;
         target = items_done + RANDOM_ITEMS / PHASES;
         while (items_done < target) random_run();
      end

      quiet = 1'b0;
      settle(8);
      if (fail_count == 0) begin
         $display("bresenham_line_rasterizer_unit test passed");
      end else begin
         $display("bresenham_line_rasterizer_unit test failed");
      end
      $finish;
   end

endmodule
